// ===== rtl/mcm_pkg.sv =====
// Package with the shared types and constants of the March C- test sequencer.
`default_nettype none

package mcm_pkg;

  localparam int unsigned WORD_COUNT_W = 17;
  localparam int unsigned CMD_ADDR_W   = 16;
  localparam int unsigned READ_DATA_W  = 32;

  // Request codes carried in req_type.
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_RUNNING = 2'd1,
    ST_PASSED  = 2'd2,
    ST_FAILED  = 2'd3
  } status_e;

  // March elements in test order; E_DRAIN waits for the answer to the final read.
  typedef enum logic [2:0] {
    E_IDLE     = 3'd0,
    E_W0_UP    = 3'd1,
    E_R0W1_UP  = 3'd2,
    E_R1W0_UP  = 3'd3,
    E_R0W1_DN  = 3'd4,
    E_R1W0_DN  = 3'd5,
    E_R0_UP    = 3'd6,
    E_DRAIN    = 3'd7
  } elem_e;

  typedef struct packed {
    logic                   req_type;
    logic [READ_DATA_W-1:0] read_data;
  } req_t;

  typedef struct packed {
    logic                   cmd_valid;
    logic                   cmd_write;
    logic [CMD_ADDR_W-1:0]  cmd_addr;
    logic                   cmd_data_ones;
    logic [1:0]             status;
    logic [2:0]             fail_element;
    logic [CMD_ADDR_W-1:0]  fail_addr;
    logic [READ_DATA_W-1:0] fail_data;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/mcm_if.sv =====
// Valid/ready channel interfaces for requests and results of the sequencer.
`default_nettype none

interface mcm_req_if;
  logic          valid;
  logic          ready;
  mcm_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mcm_rsp_if;
  logic          valid;
  logic          ready;
  mcm_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/march_c_minus_memory_test_top.sv =====
// A request transaction is held in the input register, then its result in the
// result register after the step logic.
// Throughput: one request per cycle while results are taken; the step logic has
// no multi-cycle path; both stages accept while their held transaction is taken.
// Reset: asynchronous, active low; the sequencer is idle, word_count is 65536 and
// both stages are empty. There is no memory to clear.
`default_nettype none

module march_c_minus_memory_test_top #(
  parameter int unsigned ADDR_BITS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             word_count_we_i,
  input  wire logic [mcm_pkg::WORD_COUNT_W-1:0] word_count_wdata_i,
  mcm_req_if.sink                               req_i,
  mcm_rsp_if.source                             rsp_o
);

  import mcm_pkg::*;

  logic  in_valid;
  logic  out_ready;
  req_t  in_data;
  rsp_t  step_rsp;

  mcm_stage #(.T(req_t)) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .data_i  (req_i.payload),
    .valid_o (in_valid),
    .ready_i (out_ready),
    .data_o  (in_data)
  );

  mcm_core #(
    .ADDR_BITS  (ADDR_BITS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wc_we_i    (word_count_we_i),
    .wc_wdata_i (word_count_wdata_i),
    .fire_i     (in_valid && out_ready),
    .req_i      (in_data),
    .rsp_o      (step_rsp)
  );

  mcm_stage #(.T(rsp_t)) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ready_o (out_ready),
    .data_i  (step_rsp),
    .valid_o (rsp_o.valid),
    .ready_i (rsp_o.ready),
    .data_o  (rsp_o.payload)
  );

endmodule

`default_nettype wire

// ===== rtl/mcm_stage.sv =====
// Full-rate pipeline register stage with valid/ready flow control.
`default_nettype none

module mcm_stage #(
  parameter type T = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire T     data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output T          data_o
);

  logic valid_q, valid_d;
  T     data_q;

  // The stage takes a new transaction whenever it is empty or being drained.
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/mcm_core.sv =====
// March C- sequencer state and the single-pass step logic for one request.
`default_nettype none

module mcm_core #(
  parameter int unsigned ADDR_BITS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               wc_we_i,
  input  wire logic [mcm_pkg::WORD_COUNT_W-1:0]   wc_wdata_i,
  input  wire logic                               fire_i,
  input  wire mcm_pkg::req_t                      req_i,
  output mcm_pkg::rsp_t                           rsp_o
);

  import mcm_pkg::*;

  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned CW = (AW + 1 > WORD_COUNT_W) ? AW + 1 : WORD_COUNT_W;
  localparam logic [READ_DATA_W-1:0] DMASK = (DATA_WIDTH >= READ_DATA_W) ? '1 :
      READ_DATA_W'((64'd1 << DATA_WIDTH) - 64'd1);

  logic [WORD_COUNT_W-1:0] word_count_q;
  elem_e                   element_q, element_d;
  logic [AW-1:0]           ptr_q, ptr_d;
  logic                    write_half_q, write_half_d;
  logic                    read_pending_q, read_pending_d;
  logic                    expect_ones_q, expect_ones_d;
  status_e                 status_q, status_d;
  logic [2:0]              fail_elem_q, fail_elem_d;
  logic [AW-1:0]           fail_addr_q, fail_addr_d;
  logic [READ_DATA_W-1:0]  fail_data_q, fail_data_d;
  logic [AW-1:0]           pend_addr_q, pend_addr_d;
  logic [AW:0]             run_count_q, run_count_d;

  logic [CW-1:0]           wc_ext;
  logic [CW-1:0]           wc_top;
  logic [AW:0]             clamped;
  logic [AW:0]             ptr_inc;
  logic                    last_up;
  logic [AW-1:0]           ptr_last;
  logic [READ_DATA_W-1:0]  got;
  logic                    start;

  assign wc_ext   = CW'(word_count_q);
  assign wc_top   = CW'(1) << AW;
  assign clamped  = (wc_ext == '0) ? (AW+1)'(1) :
                    (wc_ext > wc_top) ? (AW+1)'(wc_top) : (AW+1)'(wc_ext);
  assign ptr_inc  = {1'b0, ptr_q} + (AW+1)'(1);
  assign last_up  = ptr_inc >= run_count_q;
  assign ptr_last = AW'(run_count_q - (AW+1)'(1));
  assign got      = req_i.read_data & DMASK;
  assign start    = fire_i && (req_i.req_type == REQ_START);

  always_comb begin
    status_e st;
    logic    up;
    st             = status_q;
    up             = 1'b0;
    element_d      = element_q;
    ptr_d          = ptr_q;
    write_half_d   = write_half_q;
    read_pending_d = read_pending_q;
    expect_ones_d  = expect_ones_q;
    fail_elem_d    = fail_elem_q;
    fail_addr_d    = fail_addr_q;
    fail_data_d    = fail_data_q;
    pend_addr_d    = pend_addr_q;
    run_count_d    = run_count_q;
    rsp_o          = '0;

    if (fire_i) begin
      if (req_i.req_type == REQ_START) begin
        element_d      = E_W0_UP;
        ptr_d          = '0;
        write_half_d   = 1'b0;
        read_pending_d = 1'b0;
        expect_ones_d  = 1'b0;
        st             = ST_RUNNING;
        fail_elem_d    = '0;
        fail_addr_d    = '0;
        fail_data_d    = '0;
        pend_addr_d    = '0;
        run_count_d    = clamped;
      end else if (status_q == ST_RUNNING) begin
        // Check the answer to the previous read before issuing anything new.
        if (read_pending_q) begin
          read_pending_d = 1'b0;
          if (got != (expect_ones_q ? DMASK : '0)) begin
            st          = ST_FAILED;
            fail_elem_d = (element_q == E_DRAIN) ? 3'(E_R0_UP) : 3'(element_q);
            fail_addr_d = pend_addr_q;
            fail_data_d = got;
          end else if (element_q == E_DRAIN) begin
            st = ST_PASSED;
          end
        end else if (element_q == E_DRAIN || element_q == E_IDLE) begin
          st = ST_PASSED;
        end

        if (st == ST_RUNNING) begin
          up                = (element_q == E_R0W1_UP) || (element_q == E_R1W0_UP);
          rsp_o.cmd_valid   = 1'b1;
          rsp_o.cmd_addr    = CMD_ADDR_W'(ptr_q);
          unique case (element_q)
            E_W0_UP: begin
              rsp_o.cmd_write = 1'b1;
              if (last_up) begin
                element_d = E_R0W1_UP;
                ptr_d     = '0;
              end else begin
                ptr_d = ptr_inc[AW-1:0];
              end
            end
            E_R0_UP: begin
              read_pending_d = 1'b1;
              expect_ones_d  = 1'b0;
              pend_addr_d    = ptr_q;
              if (last_up) begin
                element_d = E_DRAIN;
              end else begin
                ptr_d = ptr_inc[AW-1:0];
              end
            end
            default: begin
              if (!write_half_q) begin
                read_pending_d = 1'b1;
                expect_ones_d  = (element_q == E_R1W0_UP) || (element_q == E_R1W0_DN);
                pend_addr_d    = ptr_q;
                write_half_d   = 1'b1;
              end else begin
                rsp_o.cmd_write     = 1'b1;
                rsp_o.cmd_data_ones = (element_q == E_R0W1_UP) || (element_q == E_R0W1_DN);
                write_half_d        = 1'b0;
                // Leaving an element: the two downward elements start at the top word.
                if ((up && last_up) || (!up && ptr_q == '0)) begin
                  element_d = elem_e'(element_q + 3'd1);
                  ptr_d     = (element_q == E_R1W0_UP || element_q == E_R0W1_DN) ?
                              ptr_last : '0;
                end else if (up) begin
                  ptr_d = ptr_inc[AW-1:0];
                end else begin
                  ptr_d = ptr_q - AW'(1);
                end
              end
            end
          endcase
        end
      end
    end

    status_d           = st;
    rsp_o.status       = status_d;
    rsp_o.fail_element = fail_elem_d;
    rsp_o.fail_addr    = CMD_ADDR_W'(fail_addr_d);
    rsp_o.fail_data    = fail_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q   <= WORD_COUNT_W'(65536);
      element_q      <= E_IDLE;
      ptr_q          <= '0;
      write_half_q   <= 1'b0;
      read_pending_q <= 1'b0;
      expect_ones_q  <= 1'b0;
      status_q       <= ST_IDLE;
      fail_elem_q    <= '0;
      fail_addr_q    <= '0;
      fail_data_q    <= '0;
      pend_addr_q    <= '0;
      run_count_q    <= '0;
    end else begin
      if (wc_we_i) begin
        word_count_q <= wc_wdata_i;
      end
      element_q      <= element_d;
      ptr_q          <= ptr_d;
      write_half_q   <= write_half_d;
      read_pending_q <= read_pending_d;
      expect_ones_q  <= expect_ones_d;
      status_q       <= status_d;
      fail_elem_q    <= fail_elem_d;
      fail_addr_q    <= fail_addr_d;
      fail_data_q    <= fail_data_d;
      pend_addr_q    <= pend_addr_d;
      run_count_q    <= run_count_d;
    end
  end

  a_running_has_element: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q == ST_RUNNING |-> element_q != E_IDLE)
    else $error("running with no march element selected");

  a_pending_read_element: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_pending_q |-> (element_q != E_IDLE && element_q != E_W0_UP))
    else $error("read outstanding in an element that issues no reads");

  a_write_half_element: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_half_q |-> (element_q == E_R0W1_UP || element_q == E_R1W0_UP ||
                      element_q == E_R0W1_DN || element_q == E_R1W0_DN))
    else $error("write half set outside a read-write element");

  a_pointer_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q == ST_RUNNING |-> {1'b0, ptr_q} < run_count_q)
    else $error("word pointer beyond the tested region");

  a_verdict_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q == ST_FAILED && !start) |=> status_q == ST_FAILED)
    else $error("failed status changed without a start request");

endmodule

`default_nettype wire

// ===== test/march_c_minus_memory_test_top_tb.sv =====
// Self-checking testbench for the March C- test sequencer: directed table, then random tests.
module march_c_minus_memory_test_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcm_pkg::*;

  localparam int unsigned LATENCY      = 2;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned MAX_REPORTS  = 10;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    word_count_we_i;
  logic [WORD_COUNT_W-1:0] word_count_wdata_i;

  mcm_req_if req_if ();
  mcm_rsp_if rsp_if ();

  march_c_minus_memory_test_top u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .word_count_we_i    (word_count_we_i),
    .word_count_wdata_i (word_count_wdata_i),
    .req_i              (req_if),
    .rsp_o              (rsp_if)
  );

  always #4ns clk_i = ~clk_i;

  // Shadow copy of the sequencer, advanced once per accepted request transaction.
  logic [16:0] word_count_q = 17'h10000;
  logic [16:0] run_cnt_q    = '0;
  elem_e       elem_q       = E_IDLE;
  status_e     run_q        = ST_IDLE;
  logic [15:0] ptr_q        = '0;
  logic        second_q     = 1'b0;
  logic        rd_pend_q    = 1'b0;
  logic        want_ones_q  = 1'b0;
  logic [15:0] rd_addr_q    = '0;
  elem_e       fail_elem_q  = E_IDLE;
  logic [15:0] fail_addr_q  = '0;
  logic [31:0] fail_word_q  = '0;

  rsp_t expected_rsp_q[$];
  rsp_t want_rsp;

  typedef struct {
    bit          wr_cfg;
    logic [16:0] cfg;
    req_t        req;
    bit          typed;
    rsp_t        rsp;
  } dir_row_t;

  dir_row_t dir_rows[$];

  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int unsigned n_sent, n_directed, n_checked, n_mismatch, n_cfg_writes;
  int unsigned n_tests_passed, n_tests_failed, n_restarts;

  function automatic req_t mk_req(input logic kind, input logic [31:0] data);
    req_t r;
    r.req_type  = kind;
    r.read_data = data;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input logic v, input logic w, input logic [15:0] a,
                                  input logic ones, input status_e st, input elem_e fe,
                                  input logic [15:0] fa, input logic [31:0] fd);
    rsp_t o;
    o.cmd_valid     = v;
    o.cmd_write     = w;
    o.cmd_addr      = a;
    o.cmd_data_ones = ones;
    o.status        = st;
    o.fail_element  = fe;
    o.fail_addr     = fa;
    o.fail_data     = fd;
    return o;
  endfunction

  function automatic void add_row(input bit wr_cfg, input logic [16:0] cfg, input logic kind,
                                  input logic [31:0] data, input bit typed, input rsp_t rsp);
    dir_row_t row;
    row.wr_cfg = wr_cfg;
    row.cfg    = cfg;
    row.req    = mk_req(kind, data);
    row.typed  = typed;
    row.rsp    = rsp;
    dir_rows.push_back(row);
  endfunction

  function automatic bit at_top();
    return ({1'b0, ptr_q} + 17'd1) >= run_cnt_q;
  endfunction

  function automatic void next_element();
    elem_q   = elem_e'(elem_q + 3'd1);
    second_q = 1'b0;
    if (elem_q == E_R0W1_DN || elem_q == E_R1W0_DN) begin
      ptr_q = 16'(run_cnt_q - 17'd1);
    end else begin
      ptr_q = '0;
    end
  endfunction

  function automatic void ascend();
    if (at_top()) begin
      next_element();
    end else begin
      ptr_q = ptr_q + 16'd1;
    end
  endfunction

  function automatic rsp_t march_step(input req_t r);
    rsp_t o;
    o = '0;
    if (r.req_type == REQ_START) begin
      elem_q      = E_W0_UP;
      ptr_q       = '0;
      second_q    = 1'b0;
      rd_pend_q   = 1'b0;
      want_ones_q = 1'b0;
      run_q       = ST_RUNNING;
      fail_elem_q = E_IDLE;
      fail_addr_q = '0;
      fail_word_q = '0;
      rd_addr_q   = '0;
      // A count of zero means one word, anything past the address space means all of it.
      if (word_count_q == '0) begin
        run_cnt_q = 17'd1;
      end else if (word_count_q > 17'h10000) begin
        run_cnt_q = 17'h10000;
      end else begin
        run_cnt_q = word_count_q;
      end
    end else if (run_q == ST_RUNNING) begin
      if (rd_pend_q) begin
        rd_pend_q = 1'b0;
        if (r.read_data != (want_ones_q ? 32'hFFFF_FFFF : 32'h0)) begin
          run_q       = ST_FAILED;
          fail_elem_q = (elem_q == E_DRAIN) ? E_R0_UP : elem_q;
          fail_addr_q = rd_addr_q;
          fail_word_q = r.read_data;
        end else if (elem_q == E_DRAIN) begin
          run_q = ST_PASSED;
        end
      end else if (elem_q == E_DRAIN || elem_q == E_IDLE) begin
        run_q = ST_PASSED;
      end

      if (run_q == ST_RUNNING) begin
        o.cmd_valid = 1'b1;
        o.cmd_addr  = ptr_q;
        if (elem_q == E_W0_UP) begin
          o.cmd_write = 1'b1;
          ascend();
        end else if (elem_q == E_R0_UP) begin
          rd_pend_q   = 1'b1;
          want_ones_q = 1'b0;
          rd_addr_q   = ptr_q;
          if (at_top()) begin
            elem_q = E_DRAIN;
          end else begin
            ptr_q = ptr_q + 16'd1;
          end
        end else if (!second_q) begin
          rd_pend_q   = 1'b1;
          want_ones_q = (elem_q == E_R1W0_UP || elem_q == E_R1W0_DN);
          rd_addr_q   = ptr_q;
          second_q    = 1'b1;
        end else begin
          o.cmd_write     = 1'b1;
          o.cmd_data_ones = (elem_q == E_R0W1_UP || elem_q == E_R0W1_DN);
          second_q        = 1'b0;
          if (elem_q == E_R0W1_UP || elem_q == E_R1W0_UP) begin
            ascend();
          end else if (ptr_q == '0) begin
            next_element();
          end else begin
            ptr_q = ptr_q - 16'd1;
          end
        end
      end
    end
    o.status       = run_q;
    o.fail_element = fail_elem_q;
    o.fail_addr    = fail_addr_q;
    o.fail_data    = fail_word_q;
    return o;
  endfunction

  function automatic int unsigned draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic send_req(input req_t r, input bit typed, input rsp_t typed_rsp);
    int unsigned gap;
    status_e     prev;
    rsp_t        pred;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = draw_wait(tx_burst);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    prev = run_q;
    pred = march_step(r);
    if (r.req_type == REQ_START && prev == ST_RUNNING) n_restarts++;
    if (prev == ST_RUNNING && run_q == ST_PASSED) n_tests_passed++;
    if (prev == ST_RUNNING && run_q == ST_FAILED) n_tests_failed++;
    expected_rsp_q.push_back(typed ? typed_rsp : pred);
    n_sent++;
    @(negedge clk_i);
  endtask

  // The register is only touched once the pipeline has drained.
  task automatic load_word_count(input logic [16:0] value);
    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk_i);
    repeat (2 * LATENCY + 2) @(negedge clk_i);
    word_count_we_i    <= 1'b1;
    word_count_wdata_i <= value;
    @(negedge clk_i);
    word_count_we_i <= 1'b0;
    word_count_q = value;
    n_cfg_writes++;
  endtask

  initial begin
    req_t        r;
    logic [16:0] wc;
    logic [31:0] want, d;
    int unsigned cap, k;
    rst_ni             = 1'b0;
    word_count_we_i    = 1'b0;
    word_count_wdata_i = '0;
    req_if.valid       = 1'b0;
    req_if.payload     = '0;
    rsp_if.ready       = 1'b0;

    // Before any start, then a start, a write and a restart while running.
    add_row(0, 0, REQ_ADVANCE, 32'hFFFF_FFFF, 1,
            mk_rsp(0, 0, 16'h0, 0, ST_IDLE, E_IDLE, 16'h0, 32'h0));
    add_row(0, 0, REQ_START, 32'hFFFF_FFFF, 1,
            mk_rsp(0, 0, 16'h0, 0, ST_RUNNING, E_IDLE, 16'h0, 32'h0));
    add_row(0, 0, REQ_ADVANCE, 32'h0, 1,
            mk_rsp(1, 1, 16'h0, 0, ST_RUNNING, E_IDLE, 16'h0, 32'h0));
    add_row(0, 0, REQ_ADVANCE, 32'h0, 0, '0);
    add_row(0, 0, REQ_START, 32'h0, 1,
            mk_rsp(0, 0, 16'h0, 0, ST_RUNNING, E_IDLE, 16'h0, 32'h0));
    // A zero count runs one word through all six elements with good data.
    add_row(1, 17'd0, REQ_START, 32'h0, 1,
            mk_rsp(0, 0, 16'h0, 0, ST_RUNNING, E_IDLE, 16'h0, 32'h0));
    add_row(0, 0, REQ_ADVANCE, 32'h0, 0, '0);
    add_row(0, 0, REQ_ADVANCE, 32'h0, 0, '0);
    add_row(0, 0, REQ_ADVANCE, 32'h0, 0, '0);
    add_row(0, 0, REQ_ADVANCE, 32'h0, 0, '0);
    add_row(0, 0, REQ_ADVANCE, 32'hFFFF_FFFF, 0, '0);
    add_row(0, 0, REQ_ADVANCE, 32'h0, 0, '0);
    add_row(0, 0, REQ_ADVANCE, 32'h0, 0, '0);
    add_row(0, 0, REQ_ADVANCE, 32'h0, 0, '0);
    add_row(0, 0, REQ_ADVANCE, 32'hFFFF_FFFF, 0, '0);
    add_row(0, 0, REQ_ADVANCE, 32'h0, 0, '0);
    add_row(0, 0, REQ_ADVANCE, 32'h0, 1,
            mk_rsp(0, 0, 16'h0, 0, ST_PASSED, E_IDLE, 16'h0, 32'h0));
    add_row(0, 0, REQ_ADVANCE, 32'h1234_5678, 1,
            mk_rsp(0, 0, 16'h0, 0, ST_PASSED, E_IDLE, 16'h0, 32'h0));
    // The largest register value is clamped to the full address space.
    add_row(1, 17'h1FFFF, REQ_START, 32'h0, 1,
            mk_rsp(0, 0, 16'h0, 0, ST_RUNNING, E_IDLE, 16'h0, 32'h0));
    add_row(0, 0, REQ_ADVANCE, 32'h0, 1,
            mk_rsp(1, 1, 16'h0, 0, ST_RUNNING, E_IDLE, 16'h0, 32'h0));
    // Two words; the first read of the second element returns a corrupted word.
    add_row(1, 17'd2, REQ_START, 32'h0, 1,
            mk_rsp(0, 0, 16'h0, 0, ST_RUNNING, E_IDLE, 16'h0, 32'h0));
    add_row(0, 0, REQ_ADVANCE, 32'h0, 0, '0);
    add_row(0, 0, REQ_ADVANCE, 32'h0, 0, '0);
    add_row(0, 0, REQ_ADVANCE, 32'h0, 0, '0);
    add_row(0, 0, REQ_ADVANCE, 32'h8000_0001, 1,
            mk_rsp(0, 0, 16'h0, 0, ST_FAILED, E_R0W1_UP, 16'h0, 32'h8000_0001));
    add_row(0, 0, REQ_ADVANCE, 32'h0, 1,
            mk_rsp(0, 0, 16'h0, 0, ST_FAILED, E_R0W1_UP, 16'h0, 32'h8000_0001));

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_cfg) load_word_count(dir_rows[i].cfg);
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
    end
    n_directed = n_sent;

    // Each round is mostly a well-formed test with occasional bad words and restarts.
    while (n_sent < n_directed + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 19))
          0:       wc = 17'd0;
          1:       wc = 17'h10000;
          2:       wc = 17'($urandom_range(32'h10001, 32'h1FFFF));
          3, 4:    wc = 17'($urandom_range(7, 40));
          default: wc = 17'($urandom_range(1, 6));
        endcase
        load_word_count(wc);
      end
      send_req(mk_req(REQ_START, $urandom()), 1'b0, '0);
      cap = (run_cnt_q <= 40) ? 12 * run_cnt_q + 4 : $urandom_range(10, 60);
      k = 0;
      while (run_q == ST_RUNNING && k < cap) begin
        want = want_ones_q ? 32'hFFFF_FFFF : 32'h0;
        if (!rd_pend_q) begin
          d = $urandom();
        end else if ($urandom_range(0, 49) != 0) begin
          d = want;
        end else if ($urandom_range(0, 1) == 0) begin
          d = want ^ (32'h1 << $urandom_range(0, 31));
        end else begin
          d = $urandom();
        end
        if ($urandom_range(0, 99) == 0) begin
          r = mk_req(REQ_START, d);
        end else begin
          r = mk_req(REQ_ADVANCE, d);
        end
        send_req(r, 1'b0, '0);
        k++;
      end
      repeat ($urandom_range(0, 2)) send_req(mk_req(REQ_ADVANCE, $urandom()), 1'b0, '0);
    end

    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4 * LATENCY + 4) @(posedge clk_i);

    $display("%0d requests sent (%0d from the directed table), %0d results checked,",
             n_sent, n_directed, n_checked);
    $display("%0d tests passed, %0d failed on bad words, %0d restarted, %0d count writes.",
             n_tests_passed, n_tests_failed, n_restarts, n_cfg_writes);
    if (n_mismatch == 0 && expected_rsp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: a fresh random stall before each transaction, with bursts of none.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      stall = draw_wait(rx_burst);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      n_checked++;
      if (expected_rsp_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS) begin
          $display("result %0d arrived with nothing expected: %p", n_checked, rsp_if.payload);
        end
      end else begin
        want_rsp = expected_rsp_q.pop_front();
        if (want_rsp !== rsp_if.payload) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS) begin
            $display("result %0d differs", n_checked);
            $display("  expected %p", want_rsp);
            $display("  actual   %p", rsp_if.payload);
          end
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== march_c_minus_memory_test_top.f =====
rtl/mcm_pkg.sv
rtl/mcm_if.sv
rtl/mcm_stage.sv
rtl/mcm_core.sv
rtl/march_c_minus_memory_test_top.sv
test/march_c_minus_memory_test_top_tb.sv
